### rtl/lspp_pkg.sv
// Package: shared constants, types and codes of the line segment point planner.
`default_nettype none
package lspp_pkg;

   localparam int COORD_BITS  = 12;
   localparam int MAX_POINTS  = 64;
   localparam int STEP_BITS   = 12;
   localparam int LIMIT_BITS  = 7;
   localparam int DELTA_BITS  = COORD_BITS + 1;
   localparam int COUNT_BITS  = $clog2(MAX_POINTS + 1);
   localparam int ACC_BITS    = STEP_BITS + COUNT_BITS;
   localparam int DIV_BITS    = $clog2(COORD_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_DATA_BITS = STEP_BITS;

   typedef enum logic [0:0] {
      CSR_STEP_SIZE   = 1'b0,
      CSR_POINT_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      F_IDLE,
      F_COUNT
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIV_X,
      B_DIV_Y,
      B_EMIT
   } back_state_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic                         neg_x;
      logic                         neg_y;
      logic [COORD_BITS-1:0]        mag_x;
      logic [COORD_BITS-1:0]        mag_y;
      logic [COUNT_BITS-1:0]        count;
   } segment_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] q;
      logic [COUNT_BITS-1:0] r;
   } axis_acc_type;

endpackage
`default_nettype wire

### rtl/lspp_if.sv
// Interfaces: segment request channel and point response channel.
`default_nettype none
interface lspp_req_if;
   logic valid;
   logic ready;
   logic signed [lspp_pkg::COORD_BITS-1:0] start_x;
   logic signed [lspp_pkg::COORD_BITS-1:0] start_y;
   logic signed [lspp_pkg::COORD_BITS-1:0] end_x;
   logic signed [lspp_pkg::COORD_BITS-1:0] end_y;
   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lspp_rsp_if;
   logic valid;
   logic ready;
   logic signed [lspp_pkg::COORD_BITS-1:0] point_x;
   logic signed [lspp_pkg::COORD_BITS-1:0] point_y;
   logic last_point;
   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface
`default_nettype wire

### rtl/lspp_front.sv
// Front end: configuration registers, segment accept and point count search.
`default_nettype none
module lspp_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire lspp_pkg::csr_index_type           csr_index,
   input  wire logic [lspp_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   lspp_req_if.sink                               req_bus,
   output logic                                   push,
   output lspp_pkg::segment_type                  push_data,
   input  wire logic                              queue_full
);

   lspp_pkg::front_state_type state_ff, state_in;
   logic [lspp_pkg::STEP_BITS-1:0]  step_ff;
   logic [lspp_pkg::LIMIT_BITS-1:0] limit_ff;
   lspp_pkg::segment_type           seg_ff, seg_in;
   logic [lspp_pkg::COORD_BITS-1:0] len_ff, len_in;
   logic [lspp_pkg::STEP_BITS-1:0]  inc_ff, inc_in;
   logic [lspp_pkg::COUNT_BITS-1:0] cap_ff, cap_in;
   logic [lspp_pkg::COUNT_BITS-1:0] k_ff, k_in;
   logic [lspp_pkg::ACC_BITS-1:0]   acc_ff, acc_in;

   logic signed [lspp_pkg::DELTA_BITS-1:0] dx, dy;
   logic [lspp_pkg::COORD_BITS-1:0] mag_x, mag_y, len;
   logic [lspp_pkg::COUNT_BITS-1:0] cap;
   logic [lspp_pkg::STEP_BITS-1:0]  inc;
   logic done;

   assign dx = lspp_pkg::DELTA_BITS'(req_bus.end_x) - lspp_pkg::DELTA_BITS'(req_bus.start_x);
   assign dy = lspp_pkg::DELTA_BITS'(req_bus.end_y) - lspp_pkg::DELTA_BITS'(req_bus.start_y);
   assign mag_x = dx[lspp_pkg::DELTA_BITS-1] ? lspp_pkg::COORD_BITS'(-dx)
                                             : lspp_pkg::COORD_BITS'(dx);
   assign mag_y = dy[lspp_pkg::DELTA_BITS-1] ? lspp_pkg::COORD_BITS'(-dy)
                                             : lspp_pkg::COORD_BITS'(dy);
   assign len = (mag_x > mag_y) ? mag_x : mag_y;
   assign cap = (lspp_pkg::COUNT_BITS'(limit_ff) > lspp_pkg::COUNT_BITS'(lspp_pkg::MAX_POINTS))
              ? lspp_pkg::COUNT_BITS'(lspp_pkg::MAX_POINTS) : lspp_pkg::COUNT_BITS'(limit_ff);
   assign inc = (step_ff == '0) ? lspp_pkg::STEP_BITS'(1) : step_ff;
   assign done = (acc_ff >= lspp_pkg::ACC_BITS'(len_ff)) || (k_ff == cap_ff);

   assign req_bus.ready = (state_ff == lspp_pkg::F_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= lspp_pkg::STEP_BITS'(1);
         limit_ff <= lspp_pkg::LIMIT_BITS'(lspp_pkg::MAX_POINTS);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lspp_pkg::CSR_STEP_SIZE: begin
               step_ff <= csr_write_data[lspp_pkg::STEP_BITS-1:0];
            end
            lspp_pkg::CSR_POINT_LIMIT: begin
               limit_ff <= csr_write_data[lspp_pkg::LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lspp_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
      len_ff <= len_in;
      inc_ff <= inc_in;
      cap_ff <= cap_in;
      k_ff   <= k_in;
      acc_ff <= acc_in;
   end

   always_comb begin
      state_in  = state_ff;
      seg_in    = seg_ff;
      len_in    = len_ff;
      inc_in    = inc_ff;
      cap_in    = cap_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      push      = 1'b0;
      push_data = seg_ff;
      push_data.count = k_ff;
      unique case (state_ff)
         lspp_pkg::F_IDLE: begin
            if (req_bus.valid) begin
               seg_in.start_x = req_bus.start_x;
               seg_in.start_y = req_bus.start_y;
               seg_in.neg_x   = dx[lspp_pkg::DELTA_BITS-1];
               seg_in.neg_y   = dy[lspp_pkg::DELTA_BITS-1];
               seg_in.mag_x   = mag_x;
               seg_in.mag_y   = mag_y;
               seg_in.count   = '0;
               len_in = len;
               inc_in = inc;
               cap_in = cap;
               k_in   = lspp_pkg::COUNT_BITS'(1);
               acc_in = lspp_pkg::ACC_BITS'(inc);
               // drop segments that produce no points
               if ((len != '0) && (cap != '0)) begin
                  state_in = lspp_pkg::F_COUNT;
               end
            end
         end
         lspp_pkg::F_COUNT: begin
            if (done) begin
               if (!queue_full) begin
                  push     = 1'b1;
                  state_in = lspp_pkg::F_IDLE;
               end
            end else begin
               k_in   = k_ff + lspp_pkg::COUNT_BITS'(1);
               acc_in = acc_ff + lspp_pkg::ACC_BITS'(inc_ff);
            end
         end
         default: begin
            state_in = lspp_pkg::F_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/lspp_queue.sv
// Two-entry segment queue between the front end and the point generator.
`default_nettype none
module lspp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire lspp_pkg::segment_type push_data,
   output logic                       full,
   input  wire logic                  pop,
   output lspp_pkg::segment_type      pop_data,
   output logic                       empty
);

   lspp_pkg::segment_type entry_ff [lspp_pkg::QUEUE_DEPTH];
   logic [lspp_pkg::QPTR_BITS-1:0] wr_ff, rd_ff;
   logic [lspp_pkg::QCNT_BITS-1:0] count_ff;
   logic do_push, do_pop;

   assign full     = (count_ff == lspp_pkg::QCNT_BITS'(lspp_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + lspp_pkg::QPTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + lspp_pkg::QPTR_BITS'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + lspp_pkg::QCNT_BITS'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - lspp_pkg::QCNT_BITS'(1);
         end
      end
   end

endmodule
`default_nettype wire

### rtl/lspp_back.sv
// Back end: per-axis division by the point count and point generation.
`default_nettype none
module lspp_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   output logic                       pop,
   input  wire lspp_pkg::segment_type pop_data,
   input  wire logic                  empty,
   lspp_rsp_if.source                 rsp_bus
);

   lspp_pkg::back_state_type state_ff, state_in;
   lspp_pkg::segment_type    seg_ff, seg_in;
   logic [lspp_pkg::COUNT_BITS-1:0] rem_ff, rem_in;
   logic [lspp_pkg::COORD_BITS-1:0] quo_ff, quo_in;
   logic [lspp_pkg::DIV_BITS-1:0]   bit_ff, bit_in;
   lspp_pkg::axis_acc_type base_x_ff, base_x_in, base_y_ff, base_y_in;
   lspp_pkg::axis_acc_type acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [lspp_pkg::COUNT_BITS-1:0] idx_ff, idx_in;
   logic                            out_valid_ff, out_valid_in;
   logic signed [lspp_pkg::COORD_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                            out_last_ff, out_last_in;

   logic [lspp_pkg::COUNT_BITS:0]   trial, trial_sub;
   logic                            trial_ge;
   logic [lspp_pkg::COUNT_BITS-1:0] rem_next;
   logic [lspp_pkg::COORD_BITS-1:0] quo_next;
   logic                            div_last;
   lspp_pkg::axis_acc_type          next_x, next_y;
   logic [lspp_pkg::COUNT_BITS-1:0] idx_next;

   function automatic lspp_pkg::axis_acc_type advance(lspp_pkg::axis_acc_type a,
                                                      lspp_pkg::axis_acc_type b,
                                                      logic [lspp_pkg::COUNT_BITS-1:0] n);
      logic [lspp_pkg::COUNT_BITS:0] rs;
      logic [lspp_pkg::COORD_BITS:0] qs;
      lspp_pkg::axis_acc_type res;
      rs = {1'b0, a.r} + {1'b0, b.r};
      qs = {1'b0, a.q} + {1'b0, b.q};
      if (rs >= {1'b0, n}) begin
         rs = rs - {1'b0, n};
         qs = qs + (lspp_pkg::COORD_BITS + 1)'(1);
      end
      res.q = qs[lspp_pkg::COORD_BITS-1:0];
      res.r = rs[lspp_pkg::COUNT_BITS-1:0];
      return res;
   endfunction

   function automatic logic signed [lspp_pkg::COORD_BITS-1:0] place(
         logic signed [lspp_pkg::COORD_BITS-1:0] origin, logic neg,
         logic [lspp_pkg::COORD_BITS-1:0] q);
      logic signed [lspp_pkg::DELTA_BITS-1:0] off;
      logic signed [lspp_pkg::DELTA_BITS-1:0] sum;
      off = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      sum = lspp_pkg::DELTA_BITS'(origin) + off;
      return sum[lspp_pkg::COORD_BITS-1:0];
   endfunction

   assign trial     = {rem_ff, quo_ff[lspp_pkg::COORD_BITS-1]};
   assign trial_ge  = (trial >= {1'b0, seg_ff.count});
   assign trial_sub = trial - {1'b0, seg_ff.count};
   assign rem_next  = trial_ge ? trial_sub[lspp_pkg::COUNT_BITS-1:0]
                               : trial[lspp_pkg::COUNT_BITS-1:0];
   assign quo_next  = {quo_ff[lspp_pkg::COORD_BITS-2:0], trial_ge};
   assign div_last  = (bit_ff == lspp_pkg::DIV_BITS'(lspp_pkg::COORD_BITS - 1));
   assign next_x    = advance(acc_x_ff, base_x_ff, seg_ff.count);
   assign next_y    = advance(acc_y_ff, base_y_ff, seg_ff.count);
   assign idx_next  = idx_ff + lspp_pkg::COUNT_BITS'(1);

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.point_x    = out_x_ff;
   assign rsp_bus.point_y    = out_y_ff;
   assign rsp_bus.last_point = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lspp_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff      <= seg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      bit_ff      <= bit_in;
      base_x_ff   <= base_x_in;
      base_y_ff   <= base_y_in;
      acc_x_ff    <= acc_x_in;
      acc_y_ff    <= acc_y_in;
      idx_ff      <= idx_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      seg_in       = seg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      base_x_in    = base_x_ff;
      base_y_in    = base_y_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      idx_in       = idx_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      pop          = 1'b0;
      unique case (state_ff)
         lspp_pkg::B_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               seg_in   = pop_data;
               rem_in   = '0;
               quo_in   = pop_data.mag_x;
               bit_in   = '0;
               state_in = lspp_pkg::B_DIV_X;
            end
         end
         lspp_pkg::B_DIV_X: begin
            rem_in = rem_next;
            quo_in = quo_next;
            bit_in = bit_ff + lspp_pkg::DIV_BITS'(1);
            if (div_last) begin
               base_x_in.q = quo_next;
               base_x_in.r = rem_next;
               rem_in      = '0;
               quo_in      = seg_ff.mag_y;
               bit_in      = '0;
               state_in    = lspp_pkg::B_DIV_Y;
            end
         end
         lspp_pkg::B_DIV_Y: begin
            rem_in = rem_next;
            quo_in = quo_next;
            bit_in = bit_ff + lspp_pkg::DIV_BITS'(1);
            if (div_last) begin
               base_y_in.q = quo_next;
               base_y_in.r = rem_next;
               acc_x_in    = '0;
               acc_y_in    = '0;
               idx_in      = '0;
               state_in    = lspp_pkg::B_EMIT;
            end
         end
         lspp_pkg::B_EMIT: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in = 1'b1;
               out_x_in     = place(seg_ff.start_x, seg_ff.neg_x, next_x.q);
               out_y_in     = place(seg_ff.start_y, seg_ff.neg_y, next_y.q);
               out_last_in  = (idx_next == seg_ff.count);
               acc_x_in     = next_x;
               acc_y_in     = next_y;
               idx_in       = idx_next;
               if (idx_next == seg_ff.count) begin
                  state_in = lspp_pkg::B_IDLE;
               end
            end
         end
         default: begin
            state_in = lspp_pkg::B_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/line_segment_point_planner_unit.sv
// Top level: line segment point planner, front end, queue and point generator.
//
// A segment (start_x, start_y, end_x, end_y) transfers on req_bus. The block
// emits n points on rsp_bus, n = ceil(len / step_size) capped by point_limit
// and MAX_POINTS, len the larger of |dx| and |dy|; last_point marks the last.
// Zero-length segments and a point_limit of 0 produce no transfer on rsp_bus.
// csr_write_enable writes step_size (index 0) or point_limit (index 1); write
// only while the block is idle.
// The front end takes one segment and then runs a step-accumulate search
// for n before passing it to a two-entry queue.
// The back end runs a shared restoring divider for |dx| / n and |dy| / n,
// then produces one point per cycle while the receiver is ready.
// In the back end a segment is taken from the queue, divided per axis and
// then emitted point by point; front and back overlap, so the front end
// can take a new segment while the back end still works on an earlier one.
// When the receiver stalls, the output register holds its point and the back
// end waits; the queue fills and then req_bus.ready drops.
// Synchronous reset clears the control state and restores step_size = 1 and
// point_limit = 64; nothing is in flight afterward.
`default_nettype none
module line_segment_point_planner_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   lspp_req_if.sink                                req_bus,
   lspp_rsp_if.source                              rsp_bus,
   input  wire logic                               csr_write_enable,
   input  wire lspp_pkg::csr_index_type            csr_index,
   input  wire logic [lspp_pkg::CSR_DATA_BITS-1:0] csr_write_data
);

   logic                  push, pop, full, empty;
   lspp_pkg::segment_type push_data, pop_data;

   lspp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .push             (push),
      .push_data        (push_data),
      .queue_full       (full)
   );

   lspp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   lspp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop      (pop),
      .pop_data (pop_data),
      .empty    (empty),
      .rsp_bus  (rsp_bus)
   );

endmodule
`default_nettype wire

### rtl/lspp_checker.sv
// Checker: port-level properties of the point planner and its bind.
`default_nettype none
module lspp_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_ready,
   input wire logic signed [lspp_pkg::COORD_BITS-1:0] start_x,
   input wire logic signed [lspp_pkg::COORD_BITS-1:0] start_y,
   input wire logic signed [lspp_pkg::COORD_BITS-1:0] end_x,
   input wire logic signed [lspp_pkg::COORD_BITS-1:0] end_y,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic signed [lspp_pkg::COORD_BITS-1:0] point_x,
   input wire logic signed [lspp_pkg::COORD_BITS-1:0] point_y,
   input wire logic                                  last_point
);

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(point_x) && $stable(point_y)
                                  && $stable(last_point))
      else $error("stalled point changed");

   reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not clean after reset");

   zero_length_drop: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (start_x == end_x) && (start_y == end_y) |=> req_ready)
      else $error("zero-length segment held the front end");

endmodule

bind line_segment_point_planner_unit lspp_checker u_lspp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .start_x    (req_bus.start_x),
   .start_y    (req_bus.start_y),
   .end_x      (req_bus.end_x),
   .end_y      (req_bus.end_y),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .point_x    (rsp_bus.point_x),
   .point_y    (rsp_bus.point_y),
   .last_point (rsp_bus.last_point)
);
`default_nettype wire

### tb/line_segment_point_planner_unit_test.sv
// Self-checking bench for the line segment point planner: table, random segments, point checks.
`default_nettype none
module line_segment_point_planner_unit_test;

   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 38;

   typedef struct packed {
      logic signed [lspp_pkg::COORD_BITS-1:0] x;
      logic signed [lspp_pkg::COORD_BITS-1:0] y;
      logic                                   last;
   } beam_point_type;

   typedef struct {
      logic [lspp_pkg::CSR_DATA_BITS-1:0] step;
      logic [lspp_pkg::CSR_DATA_BITS-1:0] limit;
      int sx, sy, ex, ey;
      bit typed;
      bit has_point;
      int px, py;
   } drill_row_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_write_enable;
   lspp_pkg::csr_index_type csr_index;
   logic [lspp_pkg::CSR_DATA_BITS-1:0] csr_write_data;

   lspp_req_if req_bus ();
   lspp_rsp_if rsp_bus ();

   // typed expectation travels alongside the segment payload
   logic row_typed;
   logic row_has_point;
   logic signed [lspp_pkg::COORD_BITS-1:0] row_x;
   logic signed [lspp_pkg::COORD_BITS-1:0] row_y;

   logic [lspp_pkg::STEP_BITS-1:0]  model_step;
   logic [lspp_pkg::LIMIT_BITS-1:0] model_limit;
   beam_point_type pending_points[$];
   int fail_count = 0;
   int quiet_cycles = 0;
   int tx_calm = 0;
   int rx_calm = 0;

   drill_row_type drills [20] = '{
      '{12'd1,    12'd64,     0,     0,     0,     0, 1'b1, 1'b0,     0,     0},
      '{12'd1,    12'd64,     0,     0,     1,     0, 1'b1, 1'b1,     1,     0},
      '{12'd1,    12'd64,     5,     5,     5,     4, 1'b1, 1'b1,     5,     4},
      '{12'd1,    12'd64, -2048, -2048,  2047,  2047, 1'b0, 1'b0,     0,     0},
      '{12'd1,    12'd64,  2047,  2047, -2048, -2048, 1'b0, 1'b0,     0,     0},
      '{12'd1,    12'd64,    10,     0,    20,    -3, 1'b0, 1'b0,     0,     0},
      '{12'd0,    12'd64,     0,     0,     3,     7, 1'b0, 1'b0,     0,     0},
      '{12'd0,    12'd64,   100,  -100,  -100,   100, 1'b0, 1'b0,     0,     0},
      '{12'd4095, 12'd64, -2048, -2048,  2047,  2047, 1'b1, 1'b1,  2047,  2047},
      '{12'd4095, 12'd64,  2047, -2048, -2048,  2047, 1'b1, 1'b1, -2048,  2047},
      '{12'd4095, 12'd64,     0,     0,    -1,     1, 1'b1, 1'b1,    -1,     1},
      '{12'd4095, 12'd0,      0,     0,   100,   100, 1'b1, 1'b0,     0,     0},
      '{12'd1,    12'd0,  -2048,     0,  2047,     0, 1'b1, 1'b0,     0,     0},
      '{12'd1,    12'd127, -2048,  2047,  2047, -2048, 1'b0, 1'b0,     0,     0},
      '{12'd1,    12'd100,     0,     0,     0,  -100, 1'b0, 1'b0,     0,     0},
      '{12'd1,    12'd1,  -2048, -2048,  2047,  2047, 1'b1, 1'b1,  2047,  2047},
      '{12'd1,    12'd1,      0,     0,     0, -2048, 1'b1, 1'b1,     0, -2048},
      '{12'd13,   12'hF85,    0,     0,  1000,   -37, 1'b0, 1'b0,     0,     0},
      '{12'd4094, 12'd64, -2048,     0,  2047,     1, 1'b0, 1'b0,     0,     0},
      '{12'd7,    12'd3,      1,     2,   -50,    90, 1'b0, 1'b0,     0,     0}
   };

   line_segment_point_planner_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int fit_coord(input int v);
      if (v < -2048) return -2048;
      if (v > 2047) return 2047;
      return v;
   endfunction

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic void plan_points(input int sx, input int sy, input int ex, input int ey);
      int dx, dy, ax, ay, span, pace, cap, n, i;
      beam_point_type p;
      dx = ex - sx;
      dy = ey - sy;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      span = (ax > ay) ? ax : ay;
      pace = (model_step == '0) ? 1 : int'(model_step);
      cap = (int'(model_limit) > lspp_pkg::MAX_POINTS) ? lspp_pkg::MAX_POINTS
                                                        : int'(model_limit);
      if (span == 0 || cap == 0) return;
      n = (span + pace - 1) / pace;
      if (n > cap) n = cap;
      for (i = 1; i <= n; i++) begin
         p.x = lspp_pkg::COORD_BITS'(sx + (dx * i) / n);
         p.y = lspp_pkg::COORD_BITS'(sy + (dy * i) / n);
         p.last = (i == n);
         pending_points.push_back(p);
      end
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin : observe
      beam_point_type want;
      bit moved;
      if (reset) begin
         model_step = 12'd1;
         model_limit = 7'd64;
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (pending_points.size() == 0) begin
               report_mismatch($sformatf("point (%0d,%0d) with nothing expected",
                                         rsp_bus.point_x, rsp_bus.point_y));
            end else begin
               want = pending_points.pop_front();
               if (rsp_bus.point_x !== want.x)
                  report_mismatch($sformatf("point_x %0d, want %0d", rsp_bus.point_x, want.x));
               if (rsp_bus.point_y !== want.y)
                  report_mismatch($sformatf("point_y %0d, want %0d", rsp_bus.point_y, want.y));
               if (rsp_bus.last_point !== want.last)
                  report_mismatch($sformatf("last_point %b, want %b",
                                            rsp_bus.last_point, want.last));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            if (row_typed) begin
               if (row_has_point) begin
                  want.x = row_x;
                  want.y = row_y;
                  want.last = 1'b1;
                  pending_points.push_back(want);
               end
            end else begin
               plan_points(req_bus.start_x, req_bus.start_y, req_bus.end_x, req_bus.end_y);
            end
         end
         if (csr_write_enable) begin
            if (csr_index == lspp_pkg::CSR_STEP_SIZE)
               model_step = csr_write_data[lspp_pkg::STEP_BITS-1:0];
            else model_limit = csr_write_data[lspp_pkg::LIMIT_BITS-1:0];
         end
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : receiver
      int w;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         w = draw_wait(rx_calm);
         if (w > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   task automatic send_segment(input int sx, input int sy, input int ex, input int ey,
                               input bit typed, input bit has_point, input int px, input int py);
      int w;
      w = draw_wait(tx_calm);
      if (w > 0) begin
         req_bus.valid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.start_x <= lspp_pkg::COORD_BITS'(sx);
      req_bus.start_y <= lspp_pkg::COORD_BITS'(sy);
      req_bus.end_x <= lspp_pkg::COORD_BITS'(ex);
      req_bus.end_y <= lspp_pkg::COORD_BITS'(ey);
      row_typed <= typed;
      row_has_point <= has_point;
      row_x <= lspp_pkg::COORD_BITS'(px);
      row_y <= lspp_pkg::COORD_BITS'(py);
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // drop valid, wait out every point, then let the pipeline go quiet
   task automatic drain_points();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_planner(input logic [lspp_pkg::CSR_DATA_BITS-1:0] step,
                                  input logic [lspp_pkg::CSR_DATA_BITS-1:0] limit);
      csr_write_enable <= 1'b1;
      csr_index <= lspp_pkg::CSR_STEP_SIZE;
      csr_write_data <= step;
      @(posedge clock);
      csr_index <= lspp_pkg::CSR_POINT_LIMIT;
      csr_write_data <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_segment();
      int sx, sy, ex, ey, r;
      sx = int'($urandom_range(0, 4095)) - 2048;
      sy = int'($urandom_range(0, 4095)) - 2048;
      ex = int'($urandom_range(0, 4095)) - 2048;
      ey = int'($urandom_range(0, 4095)) - 2048;
      case ($urandom_range(0, 9))
         4, 5, 6: begin
            r = $urandom_range(1, 48);
            ex = fit_coord(sx + int'($urandom_range(0, 2 * r)) - r);
            ey = fit_coord(sy + int'($urandom_range(0, 2 * r)) - r);
         end
         7: ex = sx;
         8: ey = sy;
         9: begin
            ex = sx;
            ey = sy;
         end
         default: ;
      endcase
      send_segment(sx, sy, ex, ey, 1'b0, 1'b0, 0, 0);
   endtask

   initial begin : stimulus
      logic [lspp_pkg::CSR_DATA_BITS-1:0] cur_step, cur_limit;
      int k, phase;
      req_bus.valid <= 1'b0;
      req_bus.start_x <= '0;
      req_bus.start_y <= '0;
      req_bus.end_x <= '0;
      req_bus.end_y <= '0;
      row_typed <= 1'b0;
      row_has_point <= 1'b0;
      row_x <= '0;
      row_y <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= lspp_pkg::CSR_STEP_SIZE;
      csr_write_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      cur_step = 12'd1;
      cur_limit = 12'd64;

      for (k = 0; k < 20; k++) begin
         if (drills[k].step != cur_step || drills[k].limit != cur_limit) begin
            drain_points();
            cur_step = drills[k].step;
            cur_limit = drills[k].limit;
            program_planner(cur_step, cur_limit);
         end
         send_segment(drills[k].sx, drills[k].sy, drills[k].ex, drills[k].ey,
                      drills[k].typed, drills[k].has_point, drills[k].px, drills[k].py);
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_points();
         case ($urandom_range(0, 5))
            0: cur_step = 12'd0;
            1: cur_step = 12'd1;
            2: cur_step = lspp_pkg::CSR_DATA_BITS'($urandom_range(2, 16));
            3: cur_step = lspp_pkg::CSR_DATA_BITS'($urandom_range(17, 300));
            4: cur_step = lspp_pkg::CSR_DATA_BITS'($urandom_range(301, 4094));
            default: cur_step = 12'd4095;
         endcase
         case ($urandom_range(0, 9))
            0: cur_limit = 12'd0;
            1: cur_limit = 12'd1;
            2, 3: cur_limit = 12'd64;
            4: cur_limit = lspp_pkg::CSR_DATA_BITS'($urandom_range(65, 127));
            5: cur_limit = lspp_pkg::CSR_DATA_BITS'($urandom_range(0, 4095));
            default: cur_limit = lspp_pkg::CSR_DATA_BITS'($urandom_range(2, 63));
         endcase
         program_planner(cur_step, cur_limit);
         repeat (PHASE_ITEMS) random_segment();
      end

      drain_points();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire

### files.f
rtl/lspp_pkg.sv
rtl/lspp_if.sv
rtl/lspp_front.sv
rtl/lspp_queue.sv
rtl/lspp_back.sv
rtl/line_segment_point_planner_unit.sv
rtl/lspp_checker.sv
tb/line_segment_point_planner_unit_test.sv
